// File: rtl/core/pese_pkg.sv
`default_nettype none

package pese_pkg;

   localparam int STACK_DEPTH = 128;
   localparam int DATA_W      = 32;
   localparam int SYMBOL_W    = 8;
   localparam int COUNT_W     = $clog2(STACK_DEPTH + 1);
   localparam int INDEX_W     = $clog2(STACK_DEPTH);
   localparam int ITER_W      = $clog2(DATA_W + 1);

   localparam logic [SYMBOL_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [SYMBOL_W-1:0] CHAR_NINE  = 8'h39;
   localparam logic [SYMBOL_W-1:0] CHAR_PLUS  = 8'h2B;
   localparam logic [SYMBOL_W-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [SYMBOL_W-1:0] CHAR_STAR  = 8'h2A;
   localparam logic [SYMBOL_W-1:0] CHAR_SLASH = 8'h2F;

   typedef logic [DATA_W-1:0]   data_type;
   typedef logic [SYMBOL_W-1:0] symbol_type;
   typedef logic [COUNT_W-1:0]  count_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_OVERFLOW  = 2'd1,
      STATUS_UNDERFLOW = 2'd2,
      STATUS_DIVZERO   = 2'd3
   } status_code_type;

   typedef enum logic [2:0] {
      CLS_DIGIT,
      CLS_ADD,
      CLS_SUB,
      CLS_MUL,
      CLS_DIV,
      CLS_OTHER
   } sym_class_type;

   typedef struct packed {
      logic            capture;
      logic            push;
      logic            read_second;
      logic            alu_commit;
      logic            div_start;
      logic            div_commit;
      logic            set_err;
      status_code_type err_code;
      logic            load_rsp;
   } cmd_type;

   typedef struct packed {
      sym_class_type sym_class;
      logic          last;
      logic          err_set;
      logic          full;
      logic          below_two;
      logic          second_zero;
      logic          div_done;
   } sts_type;

   function automatic sym_class_type classify(input symbol_type sym);
      sym_class_type cls;
      unique case (sym) inside
         [CHAR_ZERO:CHAR_NINE]: cls = CLS_DIGIT;
         CHAR_PLUS:             cls = CLS_ADD;
         CHAR_MINUS:            cls = CLS_SUB;
         CHAR_STAR:             cls = CLS_MUL;
         CHAR_SLASH:            cls = CLS_DIV;
         default:               cls = CLS_OTHER;
      endcase
      return cls;
   endfunction

endpackage

`default_nettype wire

// File: rtl/core/pese_req_if.sv
`default_nettype none

interface pese_req_if;
   logic                          valid;
   logic                          ready;
   logic [pese_pkg::SYMBOL_W-1:0] symbol;
   logic                          last;

   modport source (output valid, output symbol, output last, input ready);
   modport sink   (input valid, input symbol, input last, output ready);
endinterface

`default_nettype wire

// File: rtl/core/pese_rsp_if.sv
`default_nettype none

interface pese_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [pese_pkg::DATA_W-1:0] value;
   logic [1:0]                         status;

   modport source (output valid, output value, output status, input ready);
   modport sink   (input valid, input value, input status, output ready);
endinterface

`default_nettype wire

// File: rtl/core/pese_divider.sv
`default_nettype none

module pese_divider (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  pese_pkg::data_type dividend,
   input  pese_pkg::data_type divisor,
   output logic               done,
   output pese_pkg::data_type quotient
);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [pese_pkg::ITER_W-1:0]   cnt_ff, cnt_in;
   pese_pkg::data_type            rem_ff, rem_in;
   pese_pkg::data_type            quo_ff, quo_in;
   pese_pkg::data_type            den_ff, den_in;
   logic                          neg_ff, neg_in;
   logic [pese_pkg::DATA_W:0]     rem_shift;
   logic [pese_pkg::DATA_W:0]     diff;

   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      den_in    = den_ff;
      neg_in    = neg_ff;
      rem_shift = {rem_ff, quo_ff[pese_pkg::DATA_W-1]};
      diff      = rem_shift - {1'b0, den_ff};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = pese_pkg::ITER_W'(pese_pkg::DATA_W);
         rem_in  = '0;
         quo_in  = dividend[pese_pkg::DATA_W-1] ? ('0 - dividend) : dividend;
         den_in  = divisor[pese_pkg::DATA_W-1] ? ('0 - divisor) : divisor;
         neg_in  = dividend[pese_pkg::DATA_W-1] ^ divisor[pese_pkg::DATA_W-1];
      end else if (busy_ff) begin
         if (!diff[pese_pkg::DATA_W]) begin
            rem_in = diff[pese_pkg::DATA_W-1:0];
            quo_in = {quo_ff[pese_pkg::DATA_W-2:0], 1'b1};
         end else begin
            rem_in = rem_shift[pese_pkg::DATA_W-1:0];
            quo_in = {quo_ff[pese_pkg::DATA_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == pese_pkg::ITER_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? ('0 - quo_ff) : quo_ff;

endmodule

`default_nettype wire

// File: rtl/core/pese_datapath.sv
`default_nettype none

module pese_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  pese_pkg::symbol_type  req_symbol,
   input  logic                  req_last,
   input  pese_pkg::cmd_type     cmd,
   output pese_pkg::sts_type     sts,
   output pese_pkg::data_type    rsp_value,
   output logic [1:0]            rsp_status
);

   pese_pkg::data_type         mem [pese_pkg::STACK_DEPTH];
   pese_pkg::symbol_type       sym_ff;
   logic                       last_ff;
   pese_pkg::data_type         tos_ff;
   pese_pkg::data_type         rd_ff;
   pese_pkg::count_type        count_ff, count_in;
   pese_pkg::status_code_type  err_ff, err_in;
   pese_pkg::data_type         value_ff;
   pese_pkg::status_code_type  status_ff;
   pese_pkg::count_type        count_m1;
   pese_pkg::count_type        count_m2;
   pese_pkg::sym_class_type    sym_class;
   pese_pkg::data_type         product;
   pese_pkg::data_type         alu_result;
   pese_pkg::data_type         digit;
   pese_pkg::data_type         quotient;
   logic                       div_done;

   assign count_m1  = count_ff - 1'b1;
   assign count_m2  = count_m1 - 1'b1;
   assign sym_class = pese_pkg::classify(sym_ff);
   assign product   = tos_ff * rd_ff;
   assign digit     = pese_pkg::DATA_W'(sym_ff - pese_pkg::CHAR_ZERO);

   always_comb begin
      case (sym_class)
         pese_pkg::CLS_ADD: alu_result = tos_ff + rd_ff;
         pese_pkg::CLS_SUB: alu_result = tos_ff - rd_ff;
         pese_pkg::CLS_MUL: alu_result = product;
         default:           alu_result = tos_ff;
      endcase
   end

   pese_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (tos_ff),
      .divisor  (rd_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   always_ff @(posedge clock) begin
      if (cmd.push && (count_ff != '0)) begin
         mem[count_m1[pese_pkg::INDEX_W-1:0]] <= tos_ff;
      end
      if (cmd.read_second) begin
         rd_ff <= mem[count_m2[pese_pkg::INDEX_W-1:0]];
      end
   end

   always_comb begin
      count_in = count_ff;
      err_in   = err_ff;
      if (cmd.push) begin
         count_in = count_ff + 1'b1;
      end
      if (cmd.alu_commit || cmd.div_commit) begin
         count_in = count_m1;
      end
      if (cmd.set_err) begin
         err_in = cmd.err_code;
      end
      if (cmd.load_rsp) begin
         count_in = '0;
         err_in   = pese_pkg::STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         err_ff   <= pese_pkg::STATUS_OK;
      end else begin
         count_ff <= count_in;
         err_ff   <= err_in;
      end
      if (cmd.capture) begin
         sym_ff  <= req_symbol;
         last_ff <= req_last;
      end
      if (cmd.push) begin
         tos_ff <= digit;
      end else if (cmd.alu_commit) begin
         tos_ff <= alu_result;
      end else if (cmd.div_commit) begin
         tos_ff <= quotient;
      end
      if (cmd.load_rsp) begin
         if (err_ff != pese_pkg::STATUS_OK) begin
            value_ff  <= '0;
            status_ff <= err_ff;
         end else if (count_ff == '0) begin
            value_ff  <= '0;
            status_ff <= pese_pkg::STATUS_UNDERFLOW;
         end else begin
            value_ff  <= tos_ff;
            status_ff <= pese_pkg::STATUS_OK;
         end
      end
   end

   always_comb begin
      sts.sym_class   = sym_class;
      sts.last        = last_ff;
      sts.err_set     = (err_ff != pese_pkg::STATUS_OK);
      sts.full        = (count_ff >= pese_pkg::COUNT_W'(pese_pkg::STACK_DEPTH));
      sts.below_two   = (count_ff < pese_pkg::COUNT_W'(2));
      sts.second_zero = (rd_ff == '0);
      sts.div_done    = div_done;
   end

   assign rsp_value  = value_ff;
   assign rsp_status = status_ff;

   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= pese_pkg::COUNT_W'(pese_pkg::STACK_DEPTH))
      else $error("stack count beyond depth");

   a_load_clears: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |=> (count_ff == '0) && (err_ff == pese_pkg::STATUS_OK))
      else $error("stack not cleared after result");

   a_pop_count: assert property (@(posedge clock) disable iff (reset)
      (cmd.alu_commit || cmd.div_commit) |=> (count_ff == $past(count_m1)))
      else $error("operator did not drop one operand");

endmodule

`default_nettype wire

// File: rtl/core/pese_ctrl.sv
`default_nettype none

module pese_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  pese_pkg::sts_type sts,
   output pese_pkg::cmd_type cmd
);

   typedef enum logic [2:0] {
      IDLE,
      DECODE,
      EXEC,
      DIV_WAIT,
      FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = DECODE;
            end
         end
         DECODE: begin
            state_in = FINISH;
            if (!sts.err_set) begin
               unique case (sts.sym_class) inside
                  pese_pkg::CLS_DIGIT: begin
                     if (sts.full) begin
                        cmd.set_err  = 1'b1;
                        cmd.err_code = pese_pkg::STATUS_OVERFLOW;
                     end else begin
                        cmd.push = 1'b1;
                     end
                  end
                  pese_pkg::CLS_ADD, pese_pkg::CLS_SUB,
                  pese_pkg::CLS_MUL, pese_pkg::CLS_DIV: begin
                     if (sts.below_two) begin
                        cmd.set_err  = 1'b1;
                        cmd.err_code = pese_pkg::STATUS_UNDERFLOW;
                     end else begin
                        cmd.read_second = 1'b1;
                        state_in        = EXEC;
                     end
                  end
                  default: begin
                     state_in = FINISH;
                  end
               endcase
            end
         end
         EXEC: begin
            if (sts.sym_class == pese_pkg::CLS_DIV) begin
               if (sts.second_zero) begin
                  cmd.set_err  = 1'b1;
                  cmd.err_code = pese_pkg::STATUS_DIVZERO;
                  state_in     = FINISH;
               end else begin
                  cmd.div_start = 1'b1;
                  state_in      = DIV_WAIT;
               end
            end else begin
               cmd.alu_commit = 1'b1;
               state_in       = FINISH;
            end
         end
         DIV_WAIT: begin
            if (sts.div_done) begin
               cmd.div_commit = 1'b1;
               state_in       = FINISH;
            end
         end
         FINISH: begin
            if (!sts.last) begin
               state_in = IDLE;
            end else if (slot_free) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == IDLE);
   assign rsp_valid = rsp_valid_ff;

   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> !sts.second_zero)
      else $error("divider started with zero divisor");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      cmd.push |-> !sts.full)
      else $error("push onto full stack");

   a_load_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> (!rsp_valid_ff || rsp_ready))
      else $error("result overwrites pending transaction");

endmodule

`default_nettype wire

// File: rtl/core/prefix_expression_stack_evaluator_core.sv
// Takes one input transaction at a time: a digit or ignored symbol passes through
// IDLE, DECODE and FINISH; + - * add EXEC; / adds EXEC and DIV_WAIT (radix-2 divider).
// The result is registered as the FSM leaves FINISH on the last item (same order);
// a last item waits while a prior result is pending, others do not.
// Synchronous reset clears FSM, stack count, error and divider; stack memory
// is not cleared.
`default_nettype none

module prefix_expression_stack_evaluator_core (
   input  logic        clock,
   input  logic        reset,
   pese_req_if.sink    req_ch,
   pese_rsp_if.source  rsp_ch
);

   pese_pkg::cmd_type  cmd;
   pese_pkg::sts_type  sts;
   pese_pkg::data_type rsp_value;
   logic [1:0]         rsp_status;
   logic               req_ready;
   logic               rsp_valid;

   pese_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ch.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   pese_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_symbol (req_ch.symbol),
      .req_last   (req_ch.last),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_value  (rsp_value),
      .rsp_status (rsp_status)
   );

   assign req_ch.ready  = req_ready;
   assign rsp_ch.valid  = rsp_valid;
   assign rsp_ch.value  = $signed(rsp_value);
   assign rsp_ch.status = rsp_status;

endmodule

`default_nettype wire

// File: verif/tb.sv
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import pese_pkg::*;

   localparam int STALL_LIMIT = 5000;
   localparam symbol_type OPERATORS [4] = '{CHAR_PLUS, CHAR_MINUS, CHAR_STAR, CHAR_SLASH};

   typedef struct {
      data_type        value;
      status_code_type status;
   } outcome_type;

   logic clock = 1'b0;
   logic reset;

   pese_req_if req_ch ();
   pese_rsp_if rsp_ch ();

   prefix_expression_stack_evaluator_core u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   data_type        operands [STACK_DEPTH];
   int unsigned     operand_cnt;
   status_code_type sticky_err;
   outcome_type     pending_results [$];
   symbol_type      expr_q [$];
   int              mismatches;
   int              counted_items;
   int              rsp_hold;
   int              idle_cycles;
   bit              idle_on;

   function automatic void evaluate_item(symbol_type sym, logic is_last);
      data_type    top_v;
      data_type    next_v;
      data_type    mag_top;
      data_type    mag_next;
      data_type    res;
      outcome_type outcome;
      if (sticky_err == STATUS_OK) begin
         if (sym >= CHAR_ZERO && sym <= CHAR_NINE) begin
            if (operand_cnt >= STACK_DEPTH) begin
               sticky_err = STATUS_OVERFLOW;
            end else begin
               operands[operand_cnt] = data_type'(sym - CHAR_ZERO);
               operand_cnt++;
            end
         end else if (sym inside {CHAR_PLUS, CHAR_MINUS, CHAR_STAR, CHAR_SLASH}) begin
            if (operand_cnt < 2) begin
               sticky_err = STATUS_UNDERFLOW;
            end else begin
               top_v  = operands[operand_cnt-1];
               next_v = operands[operand_cnt-2];
               if (sym == CHAR_SLASH && next_v == '0) begin
                  sticky_err = STATUS_DIVZERO;
               end else begin
                  case (sym)
                     CHAR_PLUS:  res = top_v + next_v;
                     CHAR_MINUS: res = top_v - next_v;
                     CHAR_STAR:  res = top_v * next_v;
                     default: begin
                        mag_top  = top_v[DATA_W-1] ? -top_v : top_v;
                        mag_next = next_v[DATA_W-1] ? -next_v : next_v;
                        res      = mag_top / mag_next;
                        if (top_v[DATA_W-1] != next_v[DATA_W-1]) res = -res;
                     end
                  endcase
                  operand_cnt--;
                  operands[operand_cnt-1] = res;
               end
            end
         end
      end
      if (is_last) begin
         outcome.value = '0;
         if (sticky_err == STATUS_OK) begin
            if (operand_cnt == 0) sticky_err = STATUS_UNDERFLOW;
            else outcome.value = operands[operand_cnt-1];
         end
         outcome.status = sticky_err;
         pending_results.push_back(outcome);
         operand_cnt = 0;
         sticky_err  = STATUS_OK;
      end
   endfunction

   // enter and leave just after a falling edge
   task automatic send_symbol(symbol_type sym, logic is_last);
      int gap;
      gap = 0;
      if (idle_on && $urandom_range(99) < 33) gap = $urandom_range(1, 4);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid  <= 1'b1;
      req_ch.symbol <= sym;
      req_ch.last   <= is_last;
      do @(posedge clock); while (!req_ch.ready);
      evaluate_item(sym, is_last);
      if (sym inside {[CHAR_ZERO:CHAR_NINE], CHAR_PLUS, CHAR_MINUS, CHAR_STAR, CHAR_SLASH})
         counted_items++;
      @(negedge clock);
   endtask

   task automatic send_expression();
      int k;
      for (k = 0; k < expr_q.size(); k++) send_symbol(expr_q[k], k == expr_q.size() - 1);
      expr_q.delete();
   endtask

   task automatic drain_results();
      req_ch.valid <= 1'b0;
      do @(negedge clock); while (pending_results.size() != 0);
   endtask

   task automatic test_each_operation();
      expr_q = '{CHAR_ZERO + 8'd5, CHAR_ZERO + 8'd3, CHAR_PLUS};
      send_expression();
      expr_q = '{CHAR_ZERO + 8'd2, CHAR_ZERO + 8'd7, CHAR_MINUS};
      send_expression();
      expr_q = '{CHAR_ZERO + 8'd4, CHAR_ZERO + 8'd6, CHAR_STAR};
      send_expression();
      expr_q = '{CHAR_ZERO + 8'd2, CHAR_ZERO + 8'd9, CHAR_SLASH};
      send_expression();
      // negative quotient truncates toward zero
      expr_q = '{CHAR_ZERO + 8'd2, CHAR_ZERO + 8'd3, CHAR_ZERO, CHAR_MINUS, CHAR_SLASH};
      send_expression();
      expr_q = '{CHAR_NINE, 8'h00, 8'hFF};
      send_expression();
   endtask

   task automatic test_special_cases();
      expr_q = '{CHAR_PLUS};
      send_expression();
      expr_q = '{8'h00};
      send_expression();
      // divide by zero, then symbols ignored until the end
      expr_q = '{CHAR_ZERO, CHAR_ZERO + 8'd5, CHAR_SLASH, CHAR_ZERO + 8'd3, CHAR_PLUS};
      send_expression();
      expr_q = '{CHAR_ZERO + 8'd1, CHAR_ZERO + 8'd2};
      send_expression();
   endtask

   task automatic test_divide_wrap();
      // -1 below, then 8**10 * 2 on top, then divide
      expr_q = '{CHAR_ZERO + 8'd1, CHAR_ZERO, CHAR_MINUS, CHAR_ZERO + 8'd8};
      repeat (9) begin
         expr_q.push_back(CHAR_ZERO + 8'd8);
         expr_q.push_back(CHAR_STAR);
      end
      expr_q.push_back(CHAR_ZERO + 8'd2);
      expr_q.push_back(CHAR_STAR);
      expr_q.push_back(CHAR_SLASH);
      send_expression();
   endtask

   task automatic test_stack_limits();
      repeat (STACK_DEPTH) expr_q.push_back(symbol_type'(CHAR_ZERO + $urandom_range(9)));
      expr_q.push_back(CHAR_STAR);
      send_expression();
      repeat (STACK_DEPTH + 1) expr_q.push_back(symbol_type'(CHAR_ZERO + $urandom_range(9)));
      send_expression();
   endtask

   task automatic test_backpressure();
      rsp_hold = 400;
      repeat (8) begin
         expr_q.push_back(symbol_type'(CHAR_ZERO + $urandom_range(9)));
         send_expression();
      end
      drain_results();
      repeat (4) begin
         expr_q = '{CHAR_ZERO + 8'd7, CHAR_ZERO + 8'd6, CHAR_STAR};
         send_expression();
      end
   endtask

   task automatic test_random_expressions(int n);
      int goal;
      int depth;
      int steps;
      bit broken;
      goal = counted_items + n;
      while (counted_items < goal) begin
         depth  = 0;
         steps  = ($urandom_range(19) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
         broken = ($urandom_range(9) == 0);
         repeat (steps) begin
            if (depth < 2 || $urandom_range(1) == 1) begin
               expr_q.push_back(symbol_type'(CHAR_ZERO + $urandom_range(9)));
               depth++;
            end else begin
               expr_q.push_back(OPERATORS[$urandom_range(3)]);
               depth--;
            end
            if ($urandom_range(15) == 0) expr_q.push_back(symbol_type'($urandom_range(255)));
         end
         if (!broken) begin
            while (depth > 1) begin
               expr_q.push_back(OPERATORS[$urandom_range(3)]);
               depth--;
            end
         end else if ($urandom_range(1) == 1) begin
            expr_q.push_back(OPERATORS[$urandom_range(3)]);
         end
         send_expression();
      end
   endtask

   task automatic test_no_idle();
      idle_on = 1'b0;
      test_random_expressions(250);
      idle_on = 1'b1;
   endtask

   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= !(idle_on && $urandom_range(99) < 33);
         end
      end
   end

   always @(posedge clock) begin : check_results
      outcome_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: value %h status %0d", rsp_ch.value, rsp_ch.status);
         end else begin
            want = pending_results.pop_front();
            if (data_type'(rsp_ch.value) !== want.value) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("value: expected %h got %h", want.value, rsp_ch.value);
            end
            if (rsp_ch.status !== want.status) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("status: expected %0d got %0d", want.status, rsp_ch.status);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("prefix_expression_stack_evaluator_core: mismatch");
         $finish;
      end
   end

   initial begin
      reset         = 1'b1;
      req_ch.valid  = 1'b0;
      req_ch.symbol = '0;
      req_ch.last   = 1'b0;
      operand_cnt   = 0;
      sticky_err    = STATUS_OK;
      mismatches    = 0;
      counted_items = 0;
      rsp_hold      = 0;
      idle_cycles   = 0;
      idle_on       = 1'b1;
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      test_each_operation();
      test_special_cases();
      test_divide_wrap();
      test_stack_limits();
      test_backpressure();
      test_random_expressions(350);
      test_no_idle();
      test_random_expressions(300);

      drain_results();
      repeat (40) @(negedge clock);
      if (mismatches == 0 && pending_results.size() == 0)
         $display("prefix_expression_stack_evaluator_core: match");
      else
         $display("prefix_expression_stack_evaluator_core: mismatch");
      $finish;
   end

endmodule

`default_nettype wire
